FILE: design/spm_pkg.sv
// Shared types and constants for the stereo pan mixer.
// Used by the multiplier, the pan table and the top level; no dependencies.
package spm_pkg;

    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int TABLE_W = 16;
    localparam int SUM_W   = 24;
    localparam int LC_W    = 19;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [63:0] PANS_RESET = 64'h8080_8080_8080_8080;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 2'd2;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

FILE: design/spm_pan_rom.sv
// Quarter-sine pan gain table, Q1.15, with registered read.
// Depends on spm_pkg for the table width and the pi constant.
module spm_pan_rom #(
    parameter int ENTRIES = 256
) (
    input  logic                          clk,
    input  logic [$clog2(ENTRIES+1)-1:0]  addr,
    output logic [spm_pkg::TABLE_W-1:0]   data
);
    import spm_pkg::*;

    localparam logic [63:0] TURN_DIV = 64'(2 * ENTRIES);

    function automatic logic [TABLE_W-1:0] pan_sine(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        x   = (PI_Q30 * 64'(i)) / TURN_DIV;
        x2  = (x * x) >> 30;
        acc = $signed(x);
        t   = ((x * x2) >> 30) / 64'd6;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd20;
        acc = acc + $signed(t);
        t   = ((t * x2) >> 30) / 64'd42;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd72;
        acc = acc + $signed(t);
        t   = ((t * x2) >> 30) / 64'd110;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd156;
        acc = acc + $signed(t);
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 64'sd16384) >>> 15;
        if (acc > 64'sd32768)
        begin
            acc = 64'sd32768;
        end
        return acc[TABLE_W-1:0];
    endfunction

    logic [TABLE_W-1:0] rom_c [ENTRIES+1];
    logic [TABLE_W-1:0] data_reg;

    for (genvar i = 0; i <= ENTRIES; i++)
    begin : g_entry
        assign rom_c[i] = pan_sine(i);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_c[addr];
    end

    assign data = data_reg;

endmodule

FILE: design/spm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on spm_pkg for operand and product types.
module spm_mul (
    input  logic             clk,
    input  logic             en,
    input  spm_pkg::mul_op_t op_a,
    input  spm_pkg::mul_op_t op_b,
    output spm_pkg::prod_t   prod
);
    import spm_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_t'(op_a) * prod_t'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

FILE: design/stereo_pan_mixer_with_mutes.sv
// Top level: eight-channel constant-power pan mixer with mute toggles.
// Depends on spm_pkg, spm_mul (shared multiplier) and spm_pan_rom (pan table).
//
//   Channel   Signals                                       Direction
//   -------   -------------------------------------------   ---------
//   in        in_valid/in_ready, channel_index .. frame_last in
//   out       out_valid/out_ready, channel_echo .. mix_valid out
//   cfg       cfg_write, cfg_index, cfg_data                 in
//
// Each item walks the sequencer states, adding the master steps on frame_last;
// every product goes through the single registered multiplier, one per cycle.
// A finished result sits in the output register; the next item is taken while
// it waits, and the sequencer holds its final step only if that register is full.
// Reset clears mutes, button arming, both sums and the output register.
module stereo_pan_mixer_with_mutes #(
    parameter int CHANNELS          = 8,
    parameter int PAN_TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    channel_index,
    input  logic signed [15:0]            sample_in,
    input  logic signed [15:0]            level_cv,
    input  logic signed [15:0]            pan_cv,
    input  logic                          mute_button,
    input  logic signed [15:0]            master_cv,
    input  logic                          frame_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    channel_echo,
    output logic signed [15:0]            channel_out,
    output logic                          mute_lit,
    output logic signed [15:0]            mix_left,
    output logic signed [15:0]            mix_right,
    output logic                          mix_valid,
    input  logic                          cfg_write,
    input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import spm_pkg::*;

    localparam int CH_W   = $clog2(CHANNELS);
    localparam int ADDR_W = $clog2(PAN_TABLE_ENTRIES + 1);

    localparam prod_t HALF16 = prod_t'(1) <<< 15;
    localparam prod_t HALF31 = prod_t'(1) <<< 30;
    localparam prod_t HALF45 = prod_t'(1) <<< 44;
    localparam prod_t OUT_MAX = prod_t'(32767);
    localparam prod_t OUT_MIN = prod_t'(-32768);
    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'(8388607);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(8388608);
    localparam logic signed [17:0] FL_BASE  = 18'sd26214;
    localparam logic signed [17:0] FR_BASE  = 18'sd6554;
    localparam logic signed [17:0] F_CENTER = 18'sd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_CV,
        ST_TL_FL,
        ST_LEFT,
        ST_TR_FR,
        ST_RIGHT,
        ST_SUM,
        ST_MGAIN,
        ST_MLEFT,
        ST_MRIGHT,
        ST_MCLEAR,
        ST_OUT
    } state_t;

    function automatic logic signed [15:0] sat_out(input prod_t v);
        logic signed [15:0] r;
        if (v > OUT_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (v < OUT_MIN)
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > SUM_MAX)
        begin
            r = SUM_MAX[SUM_W-1:0];
        end
        else if (v < SUM_MIN)
        begin
            r = SUM_MIN[SUM_W-1:0];
        end
        else
        begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [63:0]             levels_reg;
    logic [63:0]             pans_reg;
    logic [7:0]              master_reg;
    logic [CHANNELS-1:0]     mute_reg;
    logic [CHANNELS-1:0]     armed_reg;
    logic signed [SUM_W-1:0] left_sum_reg;
    logic signed [SUM_W-1:0] right_sum_reg;

    logic                    out_valid_reg;
    logic [2:0]              echo_reg;
    logic signed [15:0]      chout_out_reg;
    logic                    lit_out_reg;
    logic signed [15:0]      mixl_out_reg;
    logic signed [15:0]      mixr_out_reg;
    logic                    mixv_out_reg;

    logic signed [15:0]      s_reg;
    logic [15:0]             g_reg;
    logic [14:0]             cvg_reg;
    logic [14:0]             mc_reg;
    logic [7:0]              p_reg;
    logic signed [17:0]      fl_reg;
    logic signed [17:0]      fr_reg;
    logic [2:0]              ch_reg;
    logic                    last_reg;
    logic                    lit_reg;
    logic [TABLE_W-1:0]      tl_reg;
    mul_op_t                 a_reg;
    mul_op_t                 hold_reg;
    logic signed [LC_W-1:0]  lc_reg;
    logic signed [15:0]      chout_reg;
    logic signed [15:0]      mixl_reg;
    logic signed [15:0]      mixr_reg;

    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic                    active;
    logic [CH_W-1:0]         ch_sel;
    logic                    flag_new;
    logic signed [17:0]      pan_x2;
    logic [7:0]              level_byte;
    logic [ADDR_W+7:0]       pan_scaled;
    logic [ADDR_W-1:0]       idx_right;
    logic [ADDR_W-1:0]       idx_left;
    logic [ADDR_W-1:0]       rom_addr;
    logic [TABLE_W-1:0]      rom_data;
    logic                    mul_en;
    mul_op_t                 op_a;
    mul_op_t                 op_b;
    prod_t                   prod;
    mul_op_t                 prod_lo;
    prod_t                   r16;
    prod_t                   r31;
    prod_t                   r45;
    logic signed [LC_W-1:0]  rc_now;
    logic signed [SUM_W:0]   lsum_add;
    logic signed [SUM_W:0]   rsum_add;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (state_reg == ST_OUT) && out_free;

    assign active   = {1'b0, channel_index} < 4'(CHANNELS);
    assign ch_sel   = channel_index[CH_W-1:0];
    assign flag_new = mute_reg[ch_sel] ^ (mute_button & armed_reg[ch_sel]);
    assign pan_x2   = {pan_cv[15], pan_cv, 1'b0};
    assign level_byte = levels_reg[8*channel_index +: 8];

    assign pan_scaled = (ADDR_W+8)'(p_reg) * (ADDR_W+8)'(PAN_TABLE_ENTRIES);
    assign idx_right  = pan_scaled[ADDR_W+7:8];
    assign idx_left   = ADDR_W'(PAN_TABLE_ENTRIES) - idx_right;
    assign rom_addr   = (state_reg == ST_GAIN) ? idx_left : idx_right;

    spm_pan_rom #(
        .ENTRIES (PAN_TABLE_ENTRIES)
    ) u_pan_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign prod_lo = prod[MUL_W-1:0];
    assign r16     = (prod + HALF16) >>> 16;
    assign r31     = (prod + HALF31) >>> 31;
    assign r45     = (prod + HALF45) >>> 45;
    assign rc_now  = r45[LC_W-1:0];
    assign lsum_add = (SUM_W+1)'(left_sum_reg) + (SUM_W+1)'(lc_reg);
    assign rsum_add = (SUM_W+1)'(right_sum_reg) + (SUM_W+1)'(rc_now);

    assign mul_en = (state_reg != ST_IDLE);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_GAIN:
            begin
                op_a = mul_op_t'(s_reg);
                op_b = mul_op_t'({1'b0, g_reg});
            end
            ST_CV:
            begin
                op_a = prod_lo;
                op_b = mul_op_t'({1'b0, cvg_reg});
            end
            ST_TL_FL:
            begin
                op_a = mul_op_t'({1'b0, tl_reg});
                op_b = mul_op_t'(fl_reg);
            end
            ST_LEFT, ST_RIGHT:
            begin
                op_a = a_reg;
                op_b = prod_lo;
            end
            ST_TR_FR:
            begin
                op_a = mul_op_t'({1'b0, rom_data});
                op_b = mul_op_t'(fr_reg);
            end
            ST_MGAIN:
            begin
                op_a = mul_op_t'({1'b0, master_reg, master_reg});
                op_b = mul_op_t'({1'b0, mc_reg});
            end
            ST_MLEFT:
            begin
                op_a = mul_op_t'(left_sum_reg);
                op_b = prod_lo;
            end
            ST_MRIGHT:
            begin
                op_a = mul_op_t'(right_sum_reg);
                op_b = hold_reg;
            end
            ST_IDLE, ST_SUM, ST_MCLEAR, ST_OUT:
            begin
                op_a = '0;
                op_b = '0;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    spm_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_GAIN : ST_IDLE;
            ST_GAIN:   state_next = ST_CV;
            ST_CV:     state_next = ST_TL_FL;
            ST_TL_FL:  state_next = ST_LEFT;
            ST_LEFT:   state_next = ST_TR_FR;
            ST_TR_FR:  state_next = ST_RIGHT;
            ST_RIGHT:  state_next = ST_SUM;
            ST_SUM:    state_next = last_reg ? ST_MGAIN : ST_OUT;
            ST_MGAIN:  state_next = ST_MLEFT;
            ST_MLEFT:  state_next = ST_MRIGHT;
            ST_MRIGHT: state_next = ST_MCLEAR;
            ST_MCLEAR: state_next = ST_OUT;
            ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            levels_reg    <= '0;
            pans_reg      <= PANS_RESET;
            master_reg    <= '0;
            mute_reg      <= '0;
            armed_reg     <= '0;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
            out_valid_reg <= 1'b0;
            echo_reg      <= '0;
            chout_out_reg <= '0;
            lit_out_reg   <= 1'b0;
            mixl_out_reg  <= '0;
            mixr_out_reg  <= '0;
            mixv_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_LEVELS: levels_reg <= cfg_data;
                    CFG_PANS:   pans_reg   <= cfg_data;
                    CFG_MASTER: master_reg <= cfg_data[7:0];
                    default:    ;
                endcase
            end

            if (accept && active)
            begin
                mute_reg[ch_sel]  <= flag_new;
                armed_reg[ch_sel] <= !mute_button;
            end

            if (state_reg == ST_SUM)
            begin
                left_sum_reg  <= sat_sum(lsum_add);
                right_sum_reg <= sat_sum(rsum_add);
            end
            else if (state_reg == ST_MCLEAR)
            begin
                left_sum_reg  <= '0;
                right_sum_reg <= '0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                echo_reg      <= ch_reg;
                chout_out_reg <= chout_reg;
                lit_out_reg   <= lit_reg;
                mixl_out_reg  <= mixl_reg;
                mixr_out_reg  <= mixr_reg;
                mixv_out_reg  <= last_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg    <= (active && !flag_new) ? sample_in : '0;
            g_reg    <= {level_byte, level_byte};
            p_reg    <= pans_reg[8*channel_index +: 8];
            cvg_reg  <= level_cv[15] ? '0 : level_cv[14:0];
            mc_reg   <= master_cv[15] ? '0 : master_cv[14:0];
            fl_reg   <= (pan_cv == '0) ? F_CENTER : FL_BASE - pan_x2;
            fr_reg   <= (pan_cv == '0) ? F_CENTER : pan_x2 + FR_BASE;
            ch_reg   <= channel_index;
            last_reg <= frame_last;
            lit_reg  <= active & flag_new;
        end

        unique case (state_reg)
            ST_CV:
            begin
                tl_reg <= rom_data;
            end
            ST_TL_FL:
            begin
                a_reg <= r16[MUL_W-1:0];
            end
            ST_TR_FR:
            begin
                lc_reg <= r45[LC_W-1:0];
            end
            ST_SUM:
            begin
                chout_reg <= sat_out(prod_t'(lc_reg) + prod_t'(rc_now));
                mixl_reg  <= '0;
                mixr_reg  <= '0;
            end
            ST_MLEFT:
            begin
                hold_reg <= prod_lo;
            end
            ST_MRIGHT:
            begin
                mixl_reg <= sat_out(r31);
            end
            ST_MCLEAR:
            begin
                mixr_reg <= sat_out(r31);
            end
            ST_IDLE, ST_GAIN, ST_LEFT, ST_RIGHT, ST_MGAIN, ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign channel_echo = echo_reg;
    assign channel_out  = chout_out_reg;
    assign mute_lit     = lit_out_reg;
    assign mix_left     = mixl_out_reg;
    assign mix_right    = mixr_out_reg;
    assign mix_valid    = mixv_out_reg;

endmodule

FILE: sim/spm_checker.sv
// Scoreboard for the stereo pan mixer: watches the config port and both channels,
// predicts every result and compares it field by field.
// Depends on spm_pkg for the register indexes, the sum width and the pi constant.
module spm_checker #(
    parameter int CHANNELS          = 8,
    parameter int PAN_TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [2:0]                    channel_index,
    input  logic signed [15:0]            sample_in,
    input  logic signed [15:0]            level_cv,
    input  logic signed [15:0]            pan_cv,
    input  logic                          mute_button,
    input  logic signed [15:0]            master_cv,
    input  logic                          frame_last,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [2:0]                    channel_echo,
    input  logic signed [15:0]            channel_out,
    input  logic                          mute_lit,
    input  logic signed [15:0]            mix_left,
    input  logic signed [15:0]            mix_right,
    input  logic                          mix_valid,
    input  logic                          cfg_write,
    input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    import spm_pkg::*;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        logic [2:0]         chan;
        logic signed [15:0] level;
        logic               lit;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               frame_end;
    } mix_result_t;

    longint      sine_q15 [PAN_TABLE_ENTRIES + 1];
    logic [63:0] level_reg;
    logic [63:0] pan_reg;
    logic [7:0]  master_reg;
    logic        mute_on [8];
    logic        armed [8];
    longint      left_acc;
    longint      right_acc;
    mix_result_t expected_q [$];
    mix_result_t want;
    int          results_seen;

    function automatic longint quarter_sine(longint unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x = (64'(PI_Q30) * i) / 64'(2 * PAN_TABLE_ENTRIES);
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + 16384) >>> 15;
        return (acc > 32768) ? 32768 : acc;
    endfunction

    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance mute and sum state by one channel sample and return its result.
    function automatic mix_result_t mix_channel(
        input logic [2:0]         chan,
        input logic signed [15:0] smp,
        input logic signed [15:0] lcv,
        input logic signed [15:0] pcv,
        input logic               btn,
        input logic signed [15:0] mcv,
        input logic               last
    );
        mix_result_t r;
        int          ch;
        int          idx;
        longint      g;
        longint      a;
        longint      cvg;
        longint      tl;
        longint      tr;
        longint      fl;
        longint      fr;
        longint      lc;
        longint      rc;
        longint      mg;
        longint      mc;
        r = '0;
        lc = 0;
        rc = 0;
        ch = int'(chan);
        r.chan = chan;
        r.frame_end = last;
        if (ch < CHANNELS)
        begin
            if (btn)
            begin
                if (armed[ch])
                begin
                    mute_on[ch] = !mute_on[ch];
                    armed[ch] = 1'b0;
                end
            end
            else
                armed[ch] = 1'b1;
            r.lit = mute_on[ch];
            if (!mute_on[ch])
            begin
                g = longint'(level_reg[8*ch +: 8]) * 257;
                idx = (int'(pan_reg[8*ch +: 8]) * PAN_TABLE_ENTRIES) >> 8;
                tl = sine_q15[PAN_TABLE_ENTRIES - idx];
                tr = sine_q15[idx];
                cvg = (lcv < 0) ? 0 : longint'(lcv);
                a = round_shift(longint'(smp) * g * cvg, 16);
                if (pcv != 0)
                begin
                    fl = floor_div(2 * (131072 - 10 * longint'(pcv)) + 5, 10);
                    fr = floor_div(2 * (10 * longint'(pcv) + 32768) + 5, 10);
                    lc = round_shift(a * tl * fl, 45);
                    rc = round_shift(a * tr * fr, 45);
                end
                else
                begin
                    lc = round_shift(a * tl, 30);
                    rc = round_shift(a * tr, 30);
                end
            end
        end
        left_acc = clamp(left_acc + lc, SUM_LO, SUM_HI);
        right_acc = clamp(right_acc + rc, SUM_LO, SUM_HI);
        r.level = 16'(clamp(lc + rc, -32768, 32767));
        if (last)
        begin
            mg = longint'(master_reg) * 257;
            mc = (mcv < 0) ? 0 : longint'(mcv);
            r.left = 16'(clamp(round_shift(left_acc * mg * mc, 31), -32768, 32767));
            r.right = 16'(clamp(round_shift(right_acc * mg * mc, 31), -32768, 32767));
            left_acc = 0;
            right_acc = 0;
        end
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i <= PAN_TABLE_ENTRIES; i++)
            sine_q15[i] = quarter_sine(longint'(i));
        mismatches = 0;
        outstanding = 0;
        results_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg = '0;
            pan_reg = PANS_RESET;
            master_reg = '0;
            for (int i = 0; i < 8; i++)
            begin
                mute_on[i] = 1'b0;
                armed[i] = 1'b0;
            end
            left_acc = 0;
            right_acc = 0;
            expected_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_LEVELS: level_reg = cfg_data;
                    CFG_PANS:   pan_reg = cfg_data;
                    CFG_MASTER: master_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_q.push_back(mix_channel(channel_index, sample_in, level_cv, pan_cv,
                                                 mute_button, master_cv, frame_last));
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: unexpected transfer, ch %0d out %0d",
                                 results_seen, channel_echo, channel_out);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (channel_echo !== want.chan || channel_out !== want.level ||
                        mute_lit !== want.lit || mix_left !== want.left ||
                        mix_right !== want.right || mix_valid !== want.frame_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: want ch %0d out %0d lit %0b mix %0d/%0d",
                                     results_seen, want.chan, want.level, want.lit,
                                     want.left, want.right,
                                     " mv %0b, got ch %0d out %0d lit %0b mix %0d/%0d",
                                     want.frame_end, channel_echo, channel_out, mute_lit,
                                     mix_left, mix_right, " mv %0b", mix_valid);
                    end
                end
            end
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// Top of the mixer testbench: clock, reset, config writes, sample stimulus and verdict.
// Depends on spm_pkg, the stereo_pan_mixer_with_mutes RTL and spm_checker.
module testbench;
    import spm_pkg::*;

    localparam int CHANNELS          = 8;
    localparam int PAN_TABLE_ENTRIES = 256;
    localparam int FRAMES_PER_PHASE  = 18;
    localparam int HOLD_AT           = 200;
    localparam int HOLD_CYCLES       = 300;
    localparam int CYCLE_LIMIT       = 500000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum int {
        PROFILE_UNITY,
        PROFILE_RANDOM,
        PROFILE_ZERO,
        PROFILE_RIGHT,
        PROFILE_CENTRE
    } cfg_profile_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           channel_index;
    logic signed [15:0]   sample_in;
    logic signed [15:0]   level_cv;
    logic signed [15:0]   pan_cv;
    logic                 mute_button;
    logic signed [15:0]   master_cv;
    logic                 frame_last;
    logic                 out_valid;
    logic                 out_ready;
    logic [2:0]           channel_echo;
    logic signed [15:0]   channel_out;
    logic                 mute_lit;
    logic signed [15:0]   mix_left;
    logic signed [15:0]   mix_right;
    logic                 mix_valid;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    int   mismatches;
    int   outstanding;
    int   sent_count;
    int   cycle_count;
    bit   in_idle_en;
    bit   out_idle_en;
    bit   held_off;
    logic btn_muted [8];
    logic btn_armed [8];

    stereo_pan_mixer_with_mutes #(
        .CHANNELS          (CHANNELS),
        .PAN_TABLE_ENTRIES (PAN_TABLE_ENTRIES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel_index (channel_index),
        .sample_in     (sample_in),
        .level_cv      (level_cv),
        .pan_cv        (pan_cv),
        .mute_button   (mute_button),
        .master_cv     (master_cv),
        .frame_last    (frame_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_echo  (channel_echo),
        .channel_out   (channel_out),
        .mute_lit      (mute_lit),
        .mix_left      (mix_left),
        .mix_right     (mix_right),
        .mix_valid     (mix_valid),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    spm_checker #(
        .CHANNELS          (CHANNELS),
        .PAN_TABLE_ENTRIES (PAN_TABLE_ENTRIES)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel_index (channel_index),
        .sample_in     (sample_in),
        .level_cv      (level_cv),
        .pan_cv        (pan_cv),
        .mute_button   (mute_button),
        .master_cv     (master_cv),
        .frame_last    (frame_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_echo  (channel_echo),
        .channel_out   (channel_out),
        .mute_lit      (mute_lit),
        .mix_left      (mix_left),
        .mix_right     (mix_right),
        .mix_valid     (mix_valid),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off once enough samples went in.
    initial
    begin
        out_ready = 1'b0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && sent_count >= HOLD_AT)
            begin
                held_off = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = !(out_idle_en && $urandom_range(99) < 30);
        end
    end

    function automatic logic signed [15:0] rand_audio();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_level_cv();
        case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'($urandom_range(32767));
            2: return 16'($urandom) | 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_pan_cv();
        case ($urandom_range(5))
            0, 1: return 16'sh0000;
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            3: return $urandom_range(1) ? 16'sh0001 : 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_master_cv();
        case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'($urandom) | 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Enter and leave on a falling edge; valid stays high after the transfer.
    task automatic offer_sample(
        input logic [2:0]         ch,
        input logic signed [15:0] smp,
        input logic signed [15:0] lcv,
        input logic signed [15:0] pcv,
        input logic               btn,
        input logic signed [15:0] mcv,
        input logic               last
    );
        while (in_idle_en && $urandom_range(99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        channel_index = ch;
        sample_in = smp;
        level_cv = lcv;
        pan_cv = pcv;
        mute_button = btn;
        master_cv = mcv;
        frame_last = last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        if (btn)
        begin
            if (btn_armed[ch])
            begin
                btn_muted[ch] = !btn_muted[ch];
                btn_armed[ch] = 1'b0;
            end
        end
        else
            btn_armed[ch] = 1'b1;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_config(input logic [63:0] levels, input logic [63:0] pans,
                                input logic [7:0] master);
        cfg_write = 1'b1;
        cfg_index = CFG_LEVELS;
        cfg_data = levels;
        @(negedge clk);
        cfg_index = CFG_PANS;
        cfg_data = pans;
        @(negedge clk);
        cfg_index = CFG_MASTER;
        cfg_data = {56'd0, master};
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic send_frame();
        logic noisy;
        noisy = ($urandom_range(7) == 0);
        for (int n = 0; n < 8; n++)
            offer_sample(noisy ? 3'($urandom) : 3'(n), rand_audio(), rand_level_cv(),
                         rand_pan_cv(), ($urandom_range(3) == 0), rand_master_cv(),
                         noisy ? ($urandom_range(3) == 0) : (n == 7));
    endtask

    task automatic run_phase(input cfg_profile_t profile, input bit idle_in,
                             input bit idle_out);
        drain();
        case (profile)
            PROFILE_UNITY:
                write_config(ALL_ONES, {$urandom, $urandom}, 8'hFF);
            PROFILE_ZERO:
                write_config(64'd0, 64'd0, 8'h00);
            PROFILE_RIGHT:
                write_config(ALL_ONES, ALL_ONES, 8'($urandom));
            PROFILE_CENTRE:
                write_config({$urandom, $urandom}, PANS_RESET, 8'hFF);
            default:
                write_config({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
        endcase
        in_idle_en = idle_in;
        out_idle_en = idle_out;
        repeat (FRAMES_PER_PHASE) send_frame();
    endtask

    // Unmute every channel, then feed one long frame that drives the sums into saturation.
    task automatic flood_mix(input logic [63:0] pans, input logic signed [15:0] smp,
                             input logic signed [15:0] pcv, input int count);
        drain();
        write_config(ALL_ONES, pans, 8'hFF);
        for (int ch = 0; ch < 8; ch++)
        begin
            if (btn_muted[ch])
            begin
                offer_sample(3'(ch), 16'sh0000, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
                offer_sample(3'(ch), 16'sh0000, 16'sh7FFF, 16'sh0000, 1'b1, 16'sh0000, 1'b0);
            end
        end
        for (int n = 0; n < count; n++)
            offer_sample(3'(n % 8), smp, 16'sh7FFF, pcv, 1'b0, 16'sh7FFF, (n == count - 1));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        channel_index = '0;
        sample_in = '0;
        level_cv = '0;
        pan_cv = '0;
        mute_button = 1'b0;
        master_cv = '0;
        frame_last = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_LEVELS;
        cfg_data = '0;
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        sent_count = 0;
        for (int i = 0; i < 8; i++)
        begin
            btn_muted[i] = 1'b0;
            btn_armed[i] = 1'b0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Reset pan positions with full channel levels and a zero master.
        write_config(ALL_ONES, PANS_RESET, 8'h00);
        offer_sample(3'd0, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd1, 16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh7FFF, 1'b1);
        drain();

        // Extreme pans per channel, unity master.
        write_config(ALL_ONES, 64'h7FC0_0040_FE01_00FF, 8'hFF);
        offer_sample(3'd7, 16'sh3039, 16'sh7FFF, 16'sh0000, 1'b1, 16'sh7FFF, 1'b0);
        offer_sample(3'd0, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd1, 16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd2, 16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd3, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd4, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd5, 16'shFFFF, 16'sh0001, 16'sh0001, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd6, 16'sh0001, 16'sh7FFF, 16'shFFFF, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd7, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh7FFF, 1'b1);
        offer_sample(3'd0, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1, 16'sh7FFF, 1'b0);
        offer_sample(3'd0, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1, 16'sh7FFF, 1'b0);
        offer_sample(3'd0, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh7FFF, 1'b0);
        offer_sample(3'd0, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1, 16'sh7FFF, 1'b0);
        offer_sample(3'd3, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh8000, 1'b1);
        offer_sample(3'd2, 16'sh8000, 16'sh4000, 16'sh0000, 1'b0, 16'sh0001, 1'b1);
        offer_sample(3'd4, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 1'b1);

        run_phase(PROFILE_UNITY, 1'b0, 1'b0);
        run_phase(PROFILE_RANDOM, 1'b1, 1'b1);
        run_phase(PROFILE_ZERO, 1'b1, 1'b0);
        run_phase(PROFILE_RIGHT, 1'b0, 1'b1);
        run_phase(PROFILE_RANDOM, 1'b1, 1'b1);
        run_phase(PROFILE_CENTRE, 1'b1, 1'b1);

        flood_mix(64'd0, 16'sh7FFF, 16'sh8000, 130);
        flood_mix(ALL_ONES, 16'sh8000, 16'sh7FFF, 160);

        drain();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
